>>> rtl/cab_pkg.sv
package cab_pkg;

  localparam int unsigned MAX_DIMENSION = 2048;

  localparam int unsigned PixW     = 32;
  localparam int unsigned DimW     = 12;
  localparam int unsigned OffW     = 13;
  localparam int unsigned AddrW    = 22;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegDestX        = 3'd0,
    RegDestY        = 3'd1,
    RegSourceWidth  = 3'd2,
    RegSourceHeight = 3'd3,
    RegCanvasWidth  = 3'd4,
    RegCanvasHeight = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [PixW-1:0] source_pixel;
    logic [PixW-1:0] canvas_pixel;
  } pix_item_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [PixW-1:0]  write_pixel;
    logic             last;
  } wr_item_t;

  typedef struct packed {
    logic signed [OffW-1:0] dest_x;
    logic signed [OffW-1:0] dest_y;
    logic [DimW-1:0]        source_width;
    logic [DimW-1:0]        source_height;
    logic [DimW-1:0]        canvas_width;
    logic [DimW-1:0]        canvas_height;
  } cfg_t;

  // Located pixel: position resolved against the canvas
  typedef struct packed {
    logic [PixW-1:0] source_pixel;
    logic [PixW-1:0] canvas_pixel;
    logic            in_canvas;
    logic            last;
    logic [DimW-1:0] cx;
    logic [DimW-1:0] cy;
  } loc_t;

endpackage

>>> rtl/cab_stream_if.sv
interface cab_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/clipped_alpha_blit.sv
// Source-over blit of an ARGB8888 image onto a canvas.
// cfg_i: register writes (index, value); always ready. Any write to a known
//   register restarts the image at column 0, row 0. Write only while idle.
// pix_i: one source pixel per transfer in row-major order, with the canvas
//   pixel currently stored at the matching place (used only for blending).
// wr_o: one result per input pixel: write enable, linear canvas address,
//   pixel with alpha 255, and a last flag on the final pixel of the image.
//   Clipped or fully transparent pixels come out with write enable low.
// Each result is registered in the locate, multiply and output registers
//   in turn before it is valid on wr_o.
// Throughput: one pixel per cycle while wr_o is ready; each stage holds
//   one pixel and the pipeline fills and drains without bubbles.
// When wr_o stalls, results hold in the output register and the stages
//   behind it keep filling; pix_i.ready drops once all three are full.
// Reset clears the counters, the pipeline valids and the registers to
//   their defaults (source 1x1, canvas 0x0, offset 0).
module clipped_alpha_blit #(
  parameter int unsigned MaxDimension = cab_pkg::MAX_DIMENSION
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cab_stream_if.sink   cfg_i,
  cab_stream_if.sink   pix_i,
  cab_stream_if.source wr_o
);
  import cab_pkg::*;

  cfg_t cfg;
  logic restart;
  logic loc_valid;
  loc_t loc;
  logic adv_blend;

  cab_cfg #(
    .MaxDimension (MaxDimension)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  cab_locate #(
    .MaxDimension (MaxDimension)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (restart),
    .pix_i       (pix_i),
    .adv_next_i  (adv_blend),
    .loc_valid_o (loc_valid),
    .loc_o       (loc)
  );

  cab_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .loc_valid_i (loc_valid),
    .loc_i       (loc),
    .adv_o       (adv_blend),
    .wr_o        (wr_o)
  );

endmodule

>>> rtl/cab_cfg.sv
module cab_cfg #(
  parameter int unsigned MaxDimension = cab_pkg::MAX_DIMENSION
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cab_stream_if.sink    cfg_i,
  output cab_pkg::cfg_t cfg_o,
  output logic          restart_o
);
  import cab_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic restart_d;
  logic [DimW-1:0] raw_dim;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] b, logic [DimW-1:0] zero_as);
    logic [DimW-1:0] r;
    if (b == '0) begin
      r = zero_as;
    end else if (32'(b) > 32'(MaxDimension)) begin
      r = DimW'(MaxDimension);
    end else begin
      r = b;
    end
    return r;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign raw_dim     = cfg_i.data.value[DimW-1:0];

  always_comb begin
    cfg_d     = cfg_q;
    restart_d = 1'b0;
    if (cfg_i.valid) begin
      restart_d = 1'b1;
      unique case (cfg_reg_e'(cfg_i.data.index))
        RegDestX:        cfg_d.dest_x        = signed'(cfg_i.data.value);
        RegDestY:        cfg_d.dest_y        = signed'(cfg_i.data.value);
        RegSourceWidth:  cfg_d.source_width  = clamp_dim(raw_dim, DimW'(1));
        RegSourceHeight: cfg_d.source_height = clamp_dim(raw_dim, DimW'(1));
        RegCanvasWidth:  cfg_d.canvas_width  = clamp_dim(raw_dim, '0);
        RegCanvasHeight: cfg_d.canvas_height = clamp_dim(raw_dim, '0);
        default:         restart_d           = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.source_width  <= DimW'(1);
      cfg_q.source_height <= DimW'(1);
      cfg_q.canvas_width  <= '0;
      cfg_q.canvas_height <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart_d;

endmodule

>>> rtl/cab_locate.sv
module cab_locate #(
  parameter int unsigned MaxDimension = cab_pkg::MAX_DIMENSION
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cab_pkg::cfg_t cfg_i,
  input  logic          restart_i,
  cab_stream_if.sink    pix_i,
  input  logic          adv_next_i,
  output logic          loc_valid_o,
  output cab_pkg::loc_t loc_o
);
  import cab_pkg::*;

  localparam int unsigned CntW = $clog2(MaxDimension);
  localparam int unsigned PosW = ((CntW > OffW) ? CntW : OffW) + 2;

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic            valid_q;
  loc_t            loc_q, loc_d;
  logic            adv, fire, col_end, row_end;
  logic signed [PosW-1:0] cx, cy;

  assign adv         = !valid_q || adv_next_i;
  assign pix_i.ready = adv;
  assign fire        = pix_i.valid && adv;

  assign col_end = (32'(col_q) + 32'd1) >= 32'(cfg_i.source_width);
  assign row_end = (32'(row_q) + 32'd1) >= 32'(cfg_i.source_height);

  assign cx = PosW'(cfg_i.dest_x) + signed'(PosW'(col_q));
  assign cy = PosW'(cfg_i.dest_y) + signed'(PosW'(row_q));

  always_comb begin
    loc_d.source_pixel = pix_i.data.source_pixel;
    loc_d.canvas_pixel = pix_i.data.canvas_pixel;
    loc_d.in_canvas = !cx[PosW-1] && !cy[PosW-1]
                   && (cx < signed'(PosW'(cfg_i.canvas_width)))
                   && (cy < signed'(PosW'(cfg_i.canvas_height)));
    loc_d.last = col_end && row_end;
    loc_d.cx   = cx[DimW-1:0];
    loc_d.cy   = cy[DimW-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (fire) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (adv) begin
        valid_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      loc_q <= loc_d;
    end
  end

  assign loc_valid_o = valid_q;
  assign loc_o       = loc_q;

  a_wrap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && loc_d.last |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after last pixel");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> col_q == '0 && row_q == '0)
    else $error("register write did not restart the image");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(cfg_i.source_width))
    else $error("column counter beyond source width");

endmodule

>>> rtl/cab_blend.sv
module cab_blend (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cab_pkg::cfg_t cfg_i,
  input  logic          loc_valid_i,
  input  cab_pkg::loc_t loc_i,
  output logic          adv_o,
  cab_stream_if.source  wr_o
);
  import cab_pkg::*;

  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned BaseW = 2 * DimW;

  typedef struct packed {
    logic                            we;
    logic                            last;
    logic                            opaque;
    logic [PixW-1:0]                 source_pixel;
    logic [BaseW-1:0]                base;
    logic [DimW-1:0]                 cx;
    logic [NumChan-1:0][ProdW-1:0]   ps;
    logic [NumChan-1:0][ProdW-1:0]   pd;
  } mul_t;

  mul_t     mul_q, mul_d;
  logic     mul_valid_q, out_valid_q;
  wr_item_t out_q, out_d;
  logic     adv_mul, adv_out;
  logic [ChanW-1:0] alpha, inv_alpha;

  assign adv_out = !out_valid_q || wr_o.ready;
  assign adv_mul = !mul_valid_q || adv_out;
  assign adv_o   = adv_mul;

  // Multiply stage: address row base and per-channel products
  always_comb begin
    alpha              = loc_i.source_pixel[PixW-1 -: ChanW];
    inv_alpha          = 8'hFF - alpha;
    mul_d.we           = loc_i.in_canvas && (alpha != '0);
    mul_d.last         = loc_i.last;
    mul_d.opaque       = alpha == 8'hFF;
    mul_d.source_pixel = loc_i.source_pixel;
    mul_d.base         = BaseW'(loc_i.cy) * BaseW'(cfg_i.canvas_width);
    mul_d.cx           = loc_i.cx;
    for (int k = 0; k < NumChan; k++) begin
      mul_d.ps[k] = ProdW'(loc_i.source_pixel[ChanW*k +: ChanW]) * ProdW'(alpha);
      mul_d.pd[k] = ProdW'(loc_i.canvas_pixel[ChanW*k +: ChanW]) * ProdW'(inv_alpha);
    end
  end

  // Sum and divide by 255: q = (x + (x >> 8) + 1) >> 8 is exact for x <= 255*255
  always_comb begin
    logic [ProdW:0]                  sum;
    logic [ProdW:0]                  t;
    logic [NumChan-1:0][ChanW-1:0]   ch;
    logic [BaseW-1:0]                addr;
    for (int k = 0; k < NumChan; k++) begin
      sum   = (ProdW+1)'(mul_q.ps[k]) + (ProdW+1)'(mul_q.pd[k]);
      t     = sum + (sum >> ChanW) + (ProdW+1)'(1);
      ch[k] = t[ChanW +: ChanW];
    end
    addr              = mul_q.base + BaseW'(mul_q.cx);
    out_d.write_enable  = mul_q.we;
    out_d.last          = mul_q.last;
    out_d.write_address = '0;
    out_d.write_pixel   = '0;
    if (mul_q.we) begin
      out_d.write_address = addr[AddrW-1:0];
      out_d.write_pixel   = mul_q.opaque ? (mul_q.source_pixel | 32'hFF00_0000)
                                         : {8'hFF, ch};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_mul) begin
        mul_valid_q <= loc_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_mul && loc_valid_i) begin
      mul_q <= mul_d;
    end
    if (adv_out && mul_valid_q) begin
      out_q <= out_d;
    end
  end

  assign wr_o.valid = out_valid_q;
  assign wr_o.data  = out_q;

  a_quiet_when_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid && !wr_o.data.write_enable |->
      wr_o.data.write_address == '0 && wr_o.data.write_pixel == '0)
    else $error("address or pixel nonzero without write");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.valid && wr_o.data.write_enable |-> wr_o.data.write_pixel[PixW-1 -: ChanW] == 8'hFF)
    else $error("written pixel alpha not opaque");

endmodule

>>> test/clipped_alpha_blit_checker.sv
module clipped_alpha_blit_checker
  import cab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_item_t cfg_data_i,
  input  logic      pix_valid_i,
  input  logic      pix_ready_i,
  input  pix_item_t pix_data_i,
  input  logic      wr_valid_i,
  input  logic      wr_ready_i,
  input  wr_item_t  wr_data_i,
  output int        errors_o,
  output int        pending_o
);

  localparam int MaxReports = 200;
  localparam logic [7:0] ClearAlpha  = 8'h00;
  localparam logic [7:0] OpaqueAlpha = 8'hFF;

  cfg_t            regs;
  logic [DimW-2:0] column;
  logic [DimW-2:0] row;
  wr_item_t        expected_writes[$];
  int              mismatches;

  function automatic logic [DimW-1:0] clamp_dim(input logic [CfgDataW-1:0] value,
                                                input logic [DimW-1:0]     zero_as);
    logic [DimW-1:0] dim;
    dim = value[DimW-1:0];
    if (dim == '0) return zero_as;
    if (dim > DimW'(MAX_DIMENSION)) return DimW'(MAX_DIMENSION);
    return dim;
  endfunction

  function automatic logic [ChanW-1:0] mix_channel(input logic [ChanW-1:0] s,
                                                   input logic [ChanW-1:0] d,
                                                   input logic [ChanW-1:0] a);
    int sum;
    sum = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return ChanW'(sum / 255);
  endfunction

  // Any known register restarts the image; unknown indexes change nothing.
  function automatic void load_register(input cfg_item_t item);
    case (item.index)
      RegDestX:        regs.dest_x = item.value;
      RegDestY:        regs.dest_y = item.value;
      RegSourceWidth:  regs.source_width = clamp_dim(item.value, DimW'(1));
      RegSourceHeight: regs.source_height = clamp_dim(item.value, DimW'(1));
      RegCanvasWidth:  regs.canvas_width = clamp_dim(item.value, '0);
      RegCanvasHeight: regs.canvas_height = clamp_dim(item.value, '0);
      default:         return;
    endcase
    column = '0;
    row = '0;
  endfunction

  function automatic wr_item_t blend_pixel(input pix_item_t p);
    wr_item_t         w;
    int               cx;
    int               cy;
    logic [ChanW-1:0] alpha;
    logic             in_canvas;
    logic             col_end;
    logic             row_end;
    w = '0;
    alpha = p.source_pixel[31:24];
    cx = int'($signed(regs.dest_x)) + int'(column);
    cy = int'($signed(regs.dest_y)) + int'(row);
    in_canvas = cx >= 0 && cy >= 0 &&
                cx < int'(regs.canvas_width) && cy < int'(regs.canvas_height);
    col_end = int'(column) + 1 >= int'(regs.source_width);
    row_end = int'(row) + 1 >= int'(regs.source_height);
    w.last = col_end && row_end;
    if (in_canvas && alpha != ClearAlpha) begin
      w.write_enable = 1'b1;
      w.write_address = AddrW'(cy * int'(regs.canvas_width) + cx);
      if (alpha == OpaqueAlpha) begin
        w.write_pixel = p.source_pixel;
      end else begin
        w.write_pixel = {OpaqueAlpha,
                         mix_channel(p.source_pixel[23:16], p.canvas_pixel[23:16], alpha),
                         mix_channel(p.source_pixel[15:8], p.canvas_pixel[15:8], alpha),
                         mix_channel(p.source_pixel[7:0], p.canvas_pixel[7:0], alpha)};
      end
    end
    // advance the raster position, wrapping after the last pixel
    if (col_end) begin
      column = '0;
      row = row_end ? '0 : row + 1'b1;
    end else begin
      column = column + 1'b1;
    end
    return w;
  endfunction

  function automatic void compare_write(input wr_item_t want, input wr_item_t got);
    if (got.write_enable !== want.write_enable || got.write_address !== want.write_address ||
        got.write_pixel !== want.write_pixel || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: mismatch exp we=%b adr=%h px=%h lst=%b got we=%b adr=%h px=%h lst=%b",
                 $time, want.write_enable, want.write_address, want.write_pixel, want.last,
                 got.write_enable, got.write_address, got.write_pixel, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wr_item_t want;
    if (!rst_ni) begin
      regs = '{dest_x: '0, dest_y: '0, source_width: DimW'(1), source_height: DimW'(1),
               canvas_width: '0, canvas_height: '0};
      column = '0;
      row = '0;
      expected_writes.delete();
      mismatches = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_register(cfg_data_i);
      // check the output before queueing, so a stray result is never matched early
      if (wr_valid_i && wr_ready_i) begin
        if (expected_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: write mismatch: expected none, got we=%b addr=%h pix=%h last=%b",
                     $time, wr_data_i.write_enable, wr_data_i.write_address,
                     wr_data_i.write_pixel, wr_data_i.last);
        end else begin
          want = expected_writes.pop_front();
          compare_write(want, wr_data_i);
        end
      end
      if (pix_valid_i && pix_ready_i) expected_writes.push_back(blend_pixel(pix_data_i));
      errors_o <= mismatches;
      pending_o <= expected_writes.size();
    end
  end

endmodule

>>> test/tb_clipped_alpha_blit.sv
module tb_clipped_alpha_blit;
  import cab_pkg::*;

  localparam int RandomItemsPerPhase = 370;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 8;
  localparam int NumRegs = int'(RegCanvasHeight) + 1;
  localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;
  localparam logic [ChanW-1:0] ClearAlpha  = 8'h00;
  localparam logic [ChanW-1:0] OpaqueAlpha = 8'hFF;

  logic clk;
  logic rst_n;
  int   src_idle_pct = 18;
  int   sink_idle_pct = 54;
  int   stall_cycles = 0;
  int   write_errors;
  int   writes_pending;

  cab_stream_if #(.T(cfg_item_t)) cfg_if ();
  cab_stream_if #(.T(pix_item_t)) pix_if ();
  cab_stream_if #(.T(wr_item_t))  wr_if ();

  clipped_alpha_blit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .wr_o   (wr_if)
  );

  clipped_alpha_blit_checker blit_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .pix_valid_i (pix_if.valid),
    .pix_ready_i (pix_if.ready),
    .pix_data_i  (pix_if.data),
    .wr_valid_i  (wr_if.valid),
    .wr_ready_i  (wr_if.ready),
    .wr_data_i   (wr_if.data),
    .errors_o    (write_errors),
    .pending_o   (writes_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    wr_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (wr_if.valid && wr_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("tb_clipped_alpha_blit: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves valid high so back-to-back writes need no extra edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: index, value: value};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_all(input logic [CfgDataW-1:0] dx, input logic [CfgDataW-1:0] dy,
                             input logic [CfgDataW-1:0] sw, input logic [CfgDataW-1:0] sh,
                             input logic [CfgDataW-1:0] cw, input logic [CfgDataW-1:0] ch);
    write_reg(RegDestX, dx);
    write_reg(RegDestY, dy);
    write_reg(RegSourceWidth, sw);
    write_reg(RegSourceHeight, sh);
    write_reg(RegCanvasWidth, cw);
    write_reg(RegCanvasHeight, ch);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PixW-1:0] source, input logic [PixW-1:0] canvas);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= '{source_pixel: source, canvas_pixel: canvas};
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // Drop valid and hold until every queued write has come out.
  task automatic drain();
    pix_if.valid <= 1'b0;
    do @(negedge clk); while (writes_pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [PixW-1:0] random_source();
    logic [ChanW-1:0] alpha;
    case ($urandom_range(3))
      0:       alpha = ClearAlpha;
      1:       alpha = OpaqueAlpha;
      default: alpha = ChanW'($urandom);
    endcase
    return {alpha, 24'($urandom)};
  endfunction

  task automatic reconfigure();
    logic [CfgDataW-1:0] vals [NumRegs];
    int                  mode;
    int                  what;
    int                  pick;
    mode = $urandom_range(9);
    what = $urandom_range(7);
    pick = $urandom_range(NumRegs - 1);
    for (int i = 0; i < NumRegs; i++) begin
      if (mode < 2) begin
        vals[i] = CfgDataW'($urandom);
      end else if (i <= int'(RegDestY)) begin
        // mode 2 parks the image at the far corner of a full-size canvas
        vals[i] = (mode == 2) ? CfgDataW'(2030 + $urandom_range(17))
                              : CfgDataW'(int'($urandom_range(16)) - 6);
      end else if (i <= int'(RegSourceHeight)) begin
        vals[i] = CfgDataW'($urandom_range(6));
      end else begin
        vals[i] = (mode == 2) ? CfgDataW'(2045 + $urandom_range(4))
                              : CfgDataW'($urandom_range(8));
      end
    end
    // what == 0 writes nothing, so the image carries on where it stopped
    for (int i = 0; i < NumRegs; i++)
      if (what >= 2 || (what == 1 && i == pick)) write_reg(CfgIdxW'(i), vals[i]);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? RegSpareHigh : RegSpareLow, CfgDataW'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int burst;
    rst_n <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    pix_if.valid <= 1'b0;
    pix_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // defaults after reset: 1x1 source on an empty canvas
    send_pixel({OpaqueAlpha, 24'hFFFFFF}, '1);
    send_pixel(32'h7F80_40C0, 32'h0000_0000);
    drain();

    program_all(13'd0, 13'd0, 13'd3, 13'd2, 13'd4, 13'd4);
    send_pixel({ClearAlpha, 24'hFFFFFF}, 32'h1234_5678);
    send_pixel({OpaqueAlpha, 24'h000000}, '1);
    send_pixel({8'h01, 24'hFFFFFF}, 32'h0000_0000);
    send_pixel({8'hFE, 24'h000000}, 32'hFFFF_FFFF);
    send_pixel(32'h80A5_5A0F, 32'h0012_34ED);
    send_pixel({OpaqueAlpha, 24'hA5C33C}, 32'h0000_0000);
    send_pixel(32'h40FF_00FF, 32'h00FF_FF00);
    drain();

    // most negative column, most positive row, zero and oversized dimensions
    program_all(13'h1000, 13'h0FFF, 13'd0, 13'd0, 13'h1FFF, 13'd4095);
    send_pixel({OpaqueAlpha, 24'h123456}, '1);
    send_pixel({8'h80, 24'h654321}, '0);
    drain();

    // top address of a full-size canvas
    program_all(13'd2047, 13'd2047, 13'd2, 13'd2, 13'd2048, 13'd2048);
    repeat (4) send_pixel({OpaqueAlpha, 24'($urandom)}, $urandom);
    drain();

    program_all(13'h1FFF, 13'h1FFF, 13'd2, 13'd2, 13'd1, 13'd1);
    repeat (4) send_pixel({8'h9C, 24'($urandom)}, $urandom);
    drain();

    // unknown indexes must not restart the image, a known one must
    program_all(13'd0, 13'd0, 13'd3, 13'd1, 13'd4, 13'd4);
    send_pixel({OpaqueAlpha, 24'h0000FF}, '0);
    drain();
    write_reg(RegSpareLow, '1);
    write_reg(RegSpareHigh, 13'h0AAA);
    cfg_if.valid <= 1'b0;
    send_pixel({OpaqueAlpha, 24'h00FF00}, '0);
    send_pixel({OpaqueAlpha, 24'hFF0000}, '0);
    send_pixel({8'h33, 24'hFFFFFF}, '1);
    drain();
    write_reg(RegDestX, 13'd1);
    cfg_if.valid <= 1'b0;
    repeat (3) send_pixel(random_source(), $urandom);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 18;
          sink_idle_pct = 54;
        end
        1: begin
          src_idle_pct = 54;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RandomItemsPerPhase) begin
        drain();
        reconfigure();
        burst = $urandom_range(1, 24);
        repeat (burst) send_pixel(random_source(), $urandom);
        sent += burst;
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (write_errors == 0 && writes_pending == 0) begin
      $display("tb_clipped_alpha_blit: done, clean");
    end else begin
      $display("tb_clipped_alpha_blit: done, errors");
    end
    $finish;
  end

endmodule
